FILE: sv/chs_pkg.sv
// ---------------------------------------------------------------------------
// chs_pkg
// Shared types and constants of the chained hash set.
// ---------------------------------------------------------------------------
package chs_pkg;

    localparam int MaxBuckets = 16;
    localparam int PoolNodes  = 256;
    localparam int KeyBits    = 32;

    localparam int BktW  = $clog2(MaxBuckets);
    localparam int NodeW = $clog2(PoolNodes);
    localparam int LinkW = NodeW + 1;
    localparam int CntW  = $clog2(PoolNodes + 1);
    localparam int BcW   = 5;

    localparam logic [LinkW-1:0] NullLink = LinkW'(PoolNodes);

    localparam logic [1:0] OpInsert = 2'd0;
    localparam logic [1:0] OpFind   = 2'd1;
    localparam logic [1:0] OpErase  = 2'd2;

    typedef struct packed {
        logic [1:0]         op;
        logic [KeyBits-1:0] key;
        logic [BktW-1:0]    bucket;
    } t_req;

    typedef struct packed {
        logic            success;
        logic            pool_full;
        logic [CntW-1:0] entry_count;
        logic            overloaded;
    } t_res;

endpackage

FILE: sv/chained_hash_set.sv
// ---------------------------------------------------------------------------
// chained_hash_set
// Hash set of signed keys with separate chaining and a fixed node pool.
// Flow: bit-serial key reduction and queue hand-off, then a done state
// (refused insert, unused op), free-stack read and insert (insert), or a
// read and compare per chain node visited (find, erase). The front takes
// no new request until it has pushed the last; it stalls while chain
// walks keep the two-entry queue full. Reset: synchronous; then the free
// stack is filled before the first op is taken. Results cannot be stalled.
// ---------------------------------------------------------------------------
module chained_hash_set (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  i_op,
    input  logic [chs_pkg::KeyBits-1:0] i_key,
    input  logic                        i_cfg_we,
    input  logic [chs_pkg::BcW-1:0]     i_cfg_data,
    output logic                        o_strobe,
    output logic                        o_success,
    output logic                        o_pool_full,
    output logic [chs_pkg::CntW-1:0]    o_entry_count,
    output logic                        o_overloaded
);
    import chs_pkg::*;

    logic [BcW-1:0] r_bc;
    logic           q_full, q_push, q_valid, q_pop, b_idle;
    t_req           f_req, q_req;
    t_res           res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_bc <= BcW'(10);
        else if (i_cfg_we) r_bc <= i_cfg_data;
    end

    chs_front u_front (
        .i_clk, .i_rst_n, .i_start(start), .i_op, .i_key, .i_bc(r_bc),
        .i_q_full(q_full), .o_busy(busy), .o_push(q_push), .o_req(f_req)
    );

    chs_queue u_queue (
        .i_clk, .i_rst_n, .i_push(q_push), .i_req(f_req), .i_pop(q_pop),
        .o_full(q_full), .o_valid(q_valid), .o_req(q_req)
    );

    chs_back u_back (
        .i_clk, .i_rst_n, .i_valid(q_valid), .i_req(q_req), .i_bc(r_bc),
        .o_pop(q_pop), .o_idle(b_idle), .o_res_valid(o_strobe), .o_res(res)
    );

    assign o_success     = res.success;
    assign o_pool_full   = res.pool_full;
    assign o_entry_count = res.entry_count;
    assign o_overloaded  = res.overloaded & b_idle | res.overloaded;

endmodule

FILE: sv/chs_front.sv
// ---------------------------------------------------------------------------
// chs_front
// Takes requests, clamps the bucket count and reduces the key magnitude
// modulo it one bit per cycle, then pushes the classified request.
// ---------------------------------------------------------------------------
module chs_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [1:0]                    i_op,
    input  logic [chs_pkg::KeyBits-1:0]   i_key,
    input  logic [chs_pkg::BcW-1:0]       i_bc,
    input  logic                          i_q_full,
    output logic                          o_busy,
    output logic                          o_push,
    output chs_pkg::t_req                 o_req
);
    import chs_pkg::*;

    localparam int CntBits = $clog2(KeyBits + 1);

    logic                 r_act, n_act;
    logic                 r_done, n_done;
    logic [1:0]           r_op;
    logic [KeyBits-1:0]   r_key;
    logic [KeyBits-1:0]   r_mag, n_mag;
    logic [BcW:0]         r_rem, n_rem;
    logic [CntBits-1:0]   r_cnt, n_cnt;
    logic [BcW-1:0]       eff;
    logic [KeyBits-1:0]   mag_in;
    logic [BcW:0]         sh;

    always_comb begin
        if (i_bc == '0)
            eff = BcW'(1);
        else if (i_bc > BcW'(MaxBuckets))
            eff = BcW'(MaxBuckets);
        else
            eff = i_bc;
    end

    assign mag_in = i_key[KeyBits-1] ? (~i_key + 1'b1) : i_key;
    assign sh     = {r_rem[BcW-1:0], r_mag[KeyBits-1]};

    assign o_busy = r_act;
    assign o_push = r_act && r_done && !i_q_full;
    assign o_req  = '{op: r_op, key: r_key, bucket: r_rem[BktW-1:0]};

    always_comb begin
        n_act  = r_act;
        n_done = r_done;
        n_mag  = r_mag;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        if (!r_act) begin
            if (i_start) begin
                n_act  = 1'b1;
                n_done = 1'b0;
                n_mag  = mag_in;
                n_rem  = '0;
                n_cnt  = '0;
            end
        end else if (!r_done) begin
            n_rem = (sh >= {1'b0, eff}) ? sh - {1'b0, eff} : sh;
            n_mag = {r_mag[KeyBits-2:0], 1'b0};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CntBits'(KeyBits - 1)) n_done = 1'b1;
        end else if (!i_q_full) begin
            n_act = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_act  <= n_act;
            r_done <= n_done;
        end
        r_mag <= n_mag;
        r_rem <= n_rem;
        r_cnt <= n_cnt;
        if (!r_act && i_start) begin
            r_op  <= i_op;
            r_key <= i_key;
        end
    end

endmodule

FILE: sv/chs_queue.sv
// ---------------------------------------------------------------------------
// chs_queue
// Two-entry request queue between the front and back parts.
// ---------------------------------------------------------------------------
module chs_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  chs_pkg::t_req i_req,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output chs_pkg::t_req o_req
);
    import chs_pkg::*;

    t_req       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_req   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
        if (i_push) r_mem[r_wp] <= i_req;
    end

endmodule

FILE: sv/chs_back.sv
// ---------------------------------------------------------------------------
// chs_back
// Carries out insert, find and erase on the bucket heads, the node pool
// and the free stack; walks a chain one node at a time, read then compare.
// ---------------------------------------------------------------------------
module chs_back (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  chs_pkg::t_req            i_req,
    input  logic [chs_pkg::BcW-1:0]  i_bc,
    output logic                     o_pop,
    output logic                     o_idle,
    output logic                     o_res_valid,
    output chs_pkg::t_res            o_res
);
    import chs_pkg::*;

    localparam logic [2:0] StIdle = 3'd0;
    localparam logic [2:0] StFree = 3'd1;
    localparam logic [2:0] StIns  = 3'd2;
    localparam logic [2:0] StRd   = 3'd3;
    localparam logic [2:0] StCmp  = 3'd4;
    localparam logic [2:0] StDone = 3'd5;

    logic [2:0]         r_st;
    t_req               r_req;
    logic [LinkW-1:0]   r_head [MaxBuckets];
    logic [KeyBits-1:0] r_nkey [PoolNodes];
    logic [LinkW-1:0]   r_nlnk [PoolNodes];
    logic [NodeW-1:0]   r_fstk [PoolNodes];
    logic [LinkW-1:0]   r_ftop;
    logic [CntW-1:0]    r_count;
    logic [NodeW:0]     r_init;
    logic [LinkW-1:0]   r_cur, r_prev;
    logic [KeyBits-1:0] r_rkey;
    logic [LinkW-1:0]   r_rlnk;
    logic [NodeW-1:0]   r_fnode;
    logic               r_ok, r_full;
    logic [BcW-1:0]     eff;
    logic [LinkW-1:0]   nxt;

    always_comb begin
        if (i_bc == '0)
            eff = BcW'(1);
        else if (i_bc > BcW'(MaxBuckets))
            eff = BcW'(MaxBuckets);
        else
            eff = i_bc;
    end

    assign o_idle      = r_st == StIdle && !r_init[NodeW];
    assign o_pop       = o_idle && i_valid;
    assign o_res_valid = r_st == StDone;
    assign o_res.success     = r_ok;
    assign o_res.pool_full   = r_full;
    assign o_res.entry_count = r_count;
    assign o_res.overloaded  = ({4'd0, r_count} * 13'd10) > ({8'd0, eff} * 13'd7);
    assign nxt = r_rlnk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= StIdle;
            r_ftop  <= LinkW'(PoolNodes);
            r_count <= '0;
            r_init  <= {1'b1, NodeW'(0)};
            for (int b = 0; b < MaxBuckets; b++) r_head[b] <= NullLink;
        end else begin
            if (r_init[NodeW]) begin
                r_fstk[r_init[NodeW-1:0]] <= NodeW'(PoolNodes - 1) - r_init[NodeW-1:0];
                if (r_init[NodeW-1:0] == NodeW'(PoolNodes - 1)) r_init <= '0;
                else r_init <= r_init + 1'b1;
            end
            unique case (r_st)
                StIdle: begin
                    if (o_pop) begin
                        r_req  <= i_req;
                        r_ok   <= 1'b0;
                        r_full <= 1'b0;
                        r_prev <= NullLink;
                        r_cur  <= r_head[i_req.bucket];
                        if (i_req.op == OpInsert) begin
                            if (r_ftop == '0) begin
                                r_full <= 1'b1;
                                r_st   <= StDone;
                            end else begin
                                r_st <= StFree;
                            end
                        end else if (i_req.op == OpFind || i_req.op == OpErase) begin
                            r_st <= StRd;
                        end else begin
                            r_st <= StDone;
                        end
                    end
                end
                StFree: begin
                    r_fnode <= r_fstk[r_ftop[NodeW-1:0] - 1'b1];
                    r_st    <= StIns;
                end
                StIns: begin
                    r_nkey[r_fnode]          <= r_req.key;
                    r_nlnk[r_fnode]          <= r_head[r_req.bucket];
                    r_head[r_req.bucket]     <= {1'b0, r_fnode};
                    r_ftop                   <= r_ftop - 1'b1;
                    r_count                  <= r_count + 1'b1;
                    r_ok                     <= 1'b1;
                    r_st                     <= StDone;
                end
                StRd: begin
                    if (r_cur[NodeW]) begin
                        r_st <= StDone;
                    end else begin
                        r_rkey <= r_nkey[r_cur[NodeW-1:0]];
                        r_rlnk <= r_nlnk[r_cur[NodeW-1:0]];
                        r_st   <= StCmp;
                    end
                end
                StCmp: begin
                    if (r_rkey == r_req.key) begin
                        r_ok <= 1'b1;
                        if (r_req.op == OpErase) begin
                            if (!r_prev[NodeW]) r_nlnk[r_prev[NodeW-1:0]] <= nxt;
                            else r_head[r_req.bucket] <= nxt;
                            r_fstk[r_ftop[NodeW-1:0]] <= r_cur[NodeW-1:0];
                            r_ftop  <= r_ftop + 1'b1;
                            r_count <= r_count - 1'b1;
                        end
                        r_st <= StDone;
                    end else begin
                        r_prev <= r_cur;
                        r_cur  <= nxt;
                        r_st   <= StRd;
                    end
                end
                StDone: r_st <= StIdle;
                default: r_st <= StIdle;
            endcase
        end
    end

endmodule

FILE: sv/chs_checker.sv
// ---------------------------------------------------------------------------
// chs_checker
// Port-level checks of the chained hash set, bound to the top level.
// ---------------------------------------------------------------------------
module chs_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        o_strobe,
    input logic                        o_success,
    input logic                        o_pool_full,
    input logic [chs_pkg::CntW-1:0]    o_entry_count
);
    import chs_pkg::*;

    a_full_no_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_pool_full |-> !o_success) else $error("full with success");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> o_entry_count <= CntW'(PoolNodes)) else $error("count range");

    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy) else $error("request not held");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("strobe");

endmodule

bind chained_hash_set chs_checker u_chk (
    .i_clk, .i_rst_n, .start, .busy, .o_strobe, .o_success, .o_pool_full,
    .o_entry_count
);
